// ----- hdl/pdfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdfs_pkg
// Types and constants shared by the pulse-distance frame sender.
// ----------------------------------------------------------------------------
package pdfs_pkg;

   localparam int unsigned CmdWidth   = 24;
   localparam int unsigned TicksWidth = 16;
   localparam int unsigned CsrIdxW    = 3;

   typedef logic [TicksWidth-1:0] ticks_type;
   typedef logic [CsrIdxW-1:0]    csr_index_type;

   typedef struct packed {
      logic                kind;
      logic [CmdWidth-1:0] command_word;
   } req_type;

   typedef struct packed {
      logic ir_active;
      logic busy_res;
      logic finished;
      logic start_rejected;
   } rsp_type;

   typedef struct packed {
      logic                is_start;
      logic [CmdWidth-1:0] command;
   } op_type;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_HDR_MARK   = 8'b0000_0010,
      PH_HDR_GAP    = 8'b0000_0100,
      PH_BIT_MARK   = 8'b0000_1000,
      PH_BIT_GAP    = 8'b0001_0000,
      PH_CLOSE_MARK = 8'b0010_0000,
      PH_REPEAT     = 8'b0100_0000,
      PH_END        = 8'b1000_0000
   } phase_type;

   localparam csr_index_type CSR_HEADER_MARK  = 3'd0;
   localparam csr_index_type CSR_HEADER_SPACE = 3'd1;
   localparam csr_index_type CSR_BIT_MARK     = 3'd2;
   localparam csr_index_type CSR_ONE_SPACE    = 3'd3;
   localparam csr_index_type CSR_ZERO_SPACE   = 3'd4;
   localparam csr_index_type CSR_REPEAT_GAP   = 3'd5;
   localparam csr_index_type CSR_END_GAP      = 3'd6;

   localparam ticks_type RST_HEADER_MARK  = 16'd4400;
   localparam ticks_type RST_HEADER_SPACE = 16'd4400;
   localparam ticks_type RST_BIT_MARK     = 16'd550;
   localparam ticks_type RST_ONE_SPACE    = 16'd1650;
   localparam ticks_type RST_ZERO_SPACE   = 16'd550;
   localparam ticks_type RST_REPEAT_GAP   = 16'd5200;
   localparam ticks_type RST_END_GAP      = 16'd5200;

   localparam logic [2:0] BIT_MSB = 3'd7;

endpackage
`default_nettype wire

// ----- hdl/pdfs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdfs_front
// Input side: classifies each item as start or tick and holds it in a
// two-entry queue until the sequencer takes it.
// ----------------------------------------------------------------------------
module pdfs_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire pdfs_pkg::req_type req_item,
   output logic                   op_valid,
   output pdfs_pkg::op_type       op,
   input  wire                    op_take
);

   pdfs_pkg::op_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;
   pdfs_pkg::op_type op_new;

   always_comb begin
      op_new.is_start = (req_item.kind == pdfs_pkg::KIND_START);
      op_new.command  = req_item.command_word;
   end

   assign full     = (count_ff == 2'd2);
   assign op_valid = (count_ff != 2'd0);
   assign op       = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = op_take && op_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pdfs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdfs_back
// Segment sequencer: holds the timing registers, counts down each segment
// and walks header, bits, closing mark and gaps of both frames.
// ----------------------------------------------------------------------------
module pdfs_back #(
   parameter int unsigned BYTES_PER_FRAME = 3
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          op_valid,
   input  wire pdfs_pkg::op_type        op,
   output logic                         op_take,
   input  wire                          out_ready,
   output logic                         rsp_valid,
   output pdfs_pkg::rsp_type            rsp,
   input  wire                          csr_write_enable,
   input  wire pdfs_pkg::csr_index_type csr_index,
   input  wire pdfs_pkg::ticks_type     csr_wdata
);

   localparam logic [2:0] LastByte = 3'(2 * BYTES_PER_FRAME - 1);

   pdfs_pkg::ticks_type hdr_mark_ff, hdr_space_ff, bit_mark_ff;
   pdfs_pkg::ticks_type one_space_ff, zero_space_ff, repeat_gap_ff, end_gap_ff;

   pdfs_pkg::phase_type              phase_ff, phase_in;
   pdfs_pkg::ticks_type              ticks_left_ff, ticks_left_in;
   logic [2:0]                       byte_pos_ff, byte_pos_in;
   logic [2:0]                       bit_pos_ff, bit_pos_in;
   logic                             second_ff, second_in;
   logic [pdfs_pkg::CmdWidth-1:0]    cmd_ff, cmd_in;

   logic        busy;
   logic [31:0] cmd_wide;
   logic [7:0]  cur_byte;
   logic        cur_bit;

   assign op_take   = op_valid && out_ready;
   assign rsp_valid = op_take;
   assign busy      = (phase_ff != pdfs_pkg::PH_IDLE);

   always_comb begin
      cmd_wide = {8'd0, cmd_ff};
      cur_byte = cmd_wide[8 * byte_pos_ff[2:1] +: 8];
      if (byte_pos_ff[0]) begin
         cur_byte = ~cur_byte;
      end
      cur_bit = cur_byte[bit_pos_ff];
   end

   always_comb begin
      phase_in      = phase_ff;
      ticks_left_in = ticks_left_ff;
      byte_pos_in   = byte_pos_ff;
      bit_pos_in    = bit_pos_ff;
      second_in     = second_ff;
      cmd_in        = cmd_ff;
      rsp           = '0;
      if (op_take) begin
         if (op.is_start) begin
            rsp.busy_res = 1'b1;
            if (busy) begin
               rsp.start_rejected = 1'b1;
            end else begin
               cmd_in        = op.command;
               second_in     = 1'b0;
               byte_pos_in   = 3'd0;
               bit_pos_in    = pdfs_pkg::BIT_MSB;
               phase_in      = pdfs_pkg::PH_HDR_MARK;
               ticks_left_in = hdr_mark_ff;
            end
         end else if (busy) begin
            rsp.busy_res  = 1'b1;
            rsp.ir_active = (phase_ff == pdfs_pkg::PH_HDR_MARK)
                         || (phase_ff == pdfs_pkg::PH_BIT_MARK)
                         || (phase_ff == pdfs_pkg::PH_CLOSE_MARK);
            if (ticks_left_ff <= 16'd1) begin
               unique case (phase_ff)
                  pdfs_pkg::PH_HDR_MARK: begin
                     phase_in      = pdfs_pkg::PH_HDR_GAP;
                     ticks_left_in = hdr_space_ff;
                  end
                  pdfs_pkg::PH_HDR_GAP: begin
                     phase_in      = pdfs_pkg::PH_BIT_MARK;
                     ticks_left_in = bit_mark_ff;
                  end
                  pdfs_pkg::PH_BIT_MARK: begin
                     phase_in      = pdfs_pkg::PH_BIT_GAP;
                     ticks_left_in = cur_bit ? one_space_ff : zero_space_ff;
                  end
                  pdfs_pkg::PH_BIT_GAP: begin
                     if (bit_pos_ff != 3'd0) begin
                        bit_pos_in    = bit_pos_ff - 3'd1;
                        phase_in      = pdfs_pkg::PH_BIT_MARK;
                        ticks_left_in = bit_mark_ff;
                     end else begin
                        bit_pos_in = pdfs_pkg::BIT_MSB;
                        if (byte_pos_ff < LastByte) begin
                           byte_pos_in   = byte_pos_ff + 3'd1;
                           phase_in      = pdfs_pkg::PH_BIT_MARK;
                           ticks_left_in = bit_mark_ff;
                        end else begin
                           phase_in      = pdfs_pkg::PH_CLOSE_MARK;
                           ticks_left_in = bit_mark_ff;
                        end
                     end
                  end
                  pdfs_pkg::PH_CLOSE_MARK: begin
                     if (second_ff) begin
                        phase_in      = pdfs_pkg::PH_END;
                        ticks_left_in = end_gap_ff;
                     end else begin
                        phase_in      = pdfs_pkg::PH_REPEAT;
                        ticks_left_in = repeat_gap_ff;
                     end
                  end
                  pdfs_pkg::PH_REPEAT: begin
                     second_in     = 1'b1;
                     byte_pos_in   = 3'd0;
                     bit_pos_in    = pdfs_pkg::BIT_MSB;
                     phase_in      = pdfs_pkg::PH_HDR_MARK;
                     ticks_left_in = hdr_mark_ff;
                  end
                  default: begin
                     rsp.finished  = 1'b1;
                     second_in     = 1'b0;
                     byte_pos_in   = 3'd0;
                     bit_pos_in    = pdfs_pkg::BIT_MSB;
                     phase_in      = pdfs_pkg::PH_IDLE;
                     ticks_left_in = '0;
                  end
               endcase
            end else begin
               ticks_left_in = ticks_left_ff - 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pdfs_pkg::PH_IDLE;
         ticks_left_ff <= '0;
         byte_pos_ff   <= 3'd0;
         bit_pos_ff    <= pdfs_pkg::BIT_MSB;
         second_ff     <= 1'b0;
         cmd_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         ticks_left_ff <= ticks_left_in;
         byte_pos_ff   <= byte_pos_in;
         bit_pos_ff    <= bit_pos_in;
         second_ff     <= second_in;
         cmd_ff        <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_mark_ff   <= pdfs_pkg::RST_HEADER_MARK;
         hdr_space_ff  <= pdfs_pkg::RST_HEADER_SPACE;
         bit_mark_ff   <= pdfs_pkg::RST_BIT_MARK;
         one_space_ff  <= pdfs_pkg::RST_ONE_SPACE;
         zero_space_ff <= pdfs_pkg::RST_ZERO_SPACE;
         repeat_gap_ff <= pdfs_pkg::RST_REPEAT_GAP;
         end_gap_ff    <= pdfs_pkg::RST_END_GAP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pdfs_pkg::CSR_HEADER_MARK:  hdr_mark_ff   <= csr_wdata;
            pdfs_pkg::CSR_HEADER_SPACE: hdr_space_ff  <= csr_wdata;
            pdfs_pkg::CSR_BIT_MARK:     bit_mark_ff   <= csr_wdata;
            pdfs_pkg::CSR_ONE_SPACE:    one_space_ff  <= csr_wdata;
            pdfs_pkg::CSR_ZERO_SPACE:   zero_space_ff <= csr_wdata;
            pdfs_pkg::CSR_REPEAT_GAP:   repeat_gap_ff <= csr_wdata;
            pdfs_pkg::CSR_END_GAP:      end_gap_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pdfs_rsp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdfs_rsp_queue
// Two-entry result queue; registers each result and holds it until popped.
// ----------------------------------------------------------------------------
module pdfs_rsp_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    rsp_valid,
   input  wire pdfs_pkg::rsp_type rsp,
   output logic                   out_ready,
   output logic                   empty,
   input  wire                    pop,
   output pdfs_pkg::rsp_type      rsp_item
);

   pdfs_pkg::rsp_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign out_ready = (count_ff != 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign do_push   = rsp_valid && out_ready;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rsp;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ir_pulse_distance_frame_sender_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_sender_core
// IR pulse-distance frame sender, envelope only.
// ----------------------------------------------------------------------------
// Push a start item with the command, then one tick item per time unit; every
// item gives one result with the envelope level and status for that tick. The
// block takes one item per clock cycle unless the result queue is full; the
// segment counter and sequencer update once per taken item, and two-entry
// queues on each side let the input and result sides stall independently.
// Both queues register their entries. Timing registers may be written only
// while no items are in flight; there is no clearing pass after reset.
module ir_pulse_distance_frame_sender_core #(
   parameter int unsigned BYTES_PER_FRAME = 3
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   output logic                         full,
   input  wire pdfs_pkg::req_type       req_item,
   output logic                         empty,
   input  wire                          pop,
   output pdfs_pkg::rsp_type            rsp_item,
   input  wire                          csr_write_enable,
   input  wire pdfs_pkg::csr_index_type csr_index,
   input  wire pdfs_pkg::ticks_type     csr_wdata
);

   logic              op_valid, op_take, out_ready, rsp_valid;
   pdfs_pkg::op_type  op;
   pdfs_pkg::rsp_type rsp;

   pdfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .op_valid (op_valid),
      .op       (op),
      .op_take  (op_take)
   );

   pdfs_back #(
      .BYTES_PER_FRAME (BYTES_PER_FRAME)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (op_valid),
      .op               (op),
      .op_take          (op_take),
      .out_ready        (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pdfs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .out_ready (out_ready),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
